/* rtl/xsimw_pkg.sv */
// Shared types and constants for the xorshift inverse minimum-weight search.
// No dependencies; imported by every module of the block.
`default_nettype none
package xsimw_pkg;

  localparam int FIELD_W  = 6;
  localparam int SHIFT_W  = 7;
  localparam int WEIGHT_W = 7;

  typedef struct packed {
    logic               load;
    logic               build;
    logic               sweep;
    logic               absorb;
    logic               tap;
    logic [SHIFT_W-1:0] amount;
  } ctrl_t;

endpackage
`default_nettype wire

/* rtl/xsimw_datapath.sv */
// Shared right shifter with the tail-pattern and inverse-word registers.
// Depends on xsimw_pkg; driven by the sequencer in the top level.
`default_nettype none
module xsimw_datapath #(
  parameter int WORD_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  xsimw_pkg::ctrl_t           ctrl_i,
  output logic [WORD_WIDTH-1:0]      z_o
);
  import xsimw_pkg::*;

  localparam logic [WORD_WIDTH-1:0] TopBit = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  logic [WORD_WIDTH-1:0] q_q, q_d;
  logic [WORD_WIDTH-1:0] z_q, z_d;
  logic [WORD_WIDTH-1:0] operand;
  logic [WORD_WIDTH-1:0] shr;

  assign operand = ctrl_i.build ? q_q : z_q;
  assign shr     = operand >> ctrl_i.amount;

  always_comb begin
    q_d = q_q;
    z_d = z_q;
    if (ctrl_i.load) begin
      q_d = TopBit;
      z_d = '0;
    end else if (ctrl_i.build) begin
      q_d = q_q | shr;
    end else if (ctrl_i.sweep) begin
      z_d = shr ^ (ctrl_i.tap ? q_q : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    z_q <= z_d;
  end

  assign z_o = z_q;

endmodule
`default_nettype wire

/* rtl/xsimw_min_track.sv */
// Population count of each inverse word and running minimum.
// Depends on xsimw_pkg; fed by xsimw_datapath.
`default_nettype none
module xsimw_min_track #(
  parameter int WORD_WIDTH = 64
) (
  input  wire logic                           clk_i,
  input  xsimw_pkg::ctrl_t                    ctrl_i,
  input  wire logic [WORD_WIDTH-1:0]          z_i,
  output logic [xsimw_pkg::WEIGHT_W-1:0]      min_o
);
  import xsimw_pkg::*;

  logic [WEIGHT_W-1:0] pop;
  logic [WEIGHT_W-1:0] min_q, min_d;

  always_comb begin
    pop = '0;
    for (int i = 0; i < WORD_WIDTH; i++) begin
      pop = pop + WEIGHT_W'(z_i[i]);
    end
  end

  always_comb begin
    min_d = min_q;
    if (ctrl_i.load) begin
      min_d = '1;
    end else if (ctrl_i.absorb && (pop < min_q)) begin
      min_d = pop;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
  end

  assign min_o = min_q;

endmodule
`default_nettype wire

/* rtl/xorshift_inverse_min_weight.sv */
// Top level: sequencer around the shared shifter and the minimum tracker.
// Depends on xsimw_pkg, xsimw_datapath and xsimw_min_track.
//
// A shift pair is taken when start_i is high and busy_o is low. The block then
// builds the right-shift tail pattern by doubling passes through its single
// shared shifter (fewer passes for large shifts), sweeps all WORD_WIDTH
// single-bit words one per cycle through the same shifter, and passes through
// a drain state and a done state to settle the minimum, with busy_o high
// throughout a pair. The result is shown for exactly one cycle with
// result_valid_o high; it cannot be held off, so capture it on that cycle.
`default_nettype none
module xorshift_inverse_min_weight #(
  parameter int WORD_WIDTH = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [xsimw_pkg::FIELD_W-1:0]     right_shift_i,
  input  wire logic [xsimw_pkg::FIELD_W-1:0]     left_shift_i,
  output logic                                   result_valid_o,
  output logic [xsimw_pkg::WEIGHT_W-1:0]         min_weight_o,
  output logic                                   conjecture_broken_o
);
  import xsimw_pkg::*;

  localparam int TW = $clog2(WORD_WIDTH);
  localparam logic [TW-1:0]      TLast  = TW'(WORD_WIDTH - 1);
  localparam logic [SHIFT_W-1:0] WordW7 = SHIFT_W'(WORD_WIDTH);
  localparam logic [7:0]         WordW8 = 8'(WORD_WIDTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BUILD = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [SHIFT_W-1:0] s_q, s_d;
  logic [FIELD_W-1:0] cnt_q, cnt_d;
  logic [TW-1:0]      t_q, t_d;
  logic [FIELD_W-1:0] r_q, r_d;
  logic [FIELD_W-1:0] ell_q, ell_d;
  logic               absorb_q;

  logic               accept;
  logic               build_go;
  ctrl_t              ctrl;
  logic [WORD_WIDTH-1:0] z;
  logic [WEIGHT_W-1:0]   min_w;

  logic [7:0] r8, ell8, twice_r, twice_ell;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign build_go = (state_q == S_BUILD) && (s_q != '0) && (s_q < WordW7);

  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    cnt_d   = cnt_q;
    t_d     = t_q;
    r_d     = r_q;
    ell_d   = ell_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_BUILD;
          s_d     = {1'b0, right_shift_i};
          cnt_d   = '0;
          t_d     = '0;
          r_d     = right_shift_i;
          ell_d   = left_shift_i;
        end
      end
      S_BUILD: begin
        if (build_go) begin
          s_d = s_q << 1;
        end else begin
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cnt_d = (cnt_q == ell_q - FIELD_W'(1)) ? '0 : cnt_q + FIELD_W'(1);
        t_d   = t_q + TW'(1);
        if (t_q == TLast) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      absorb_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      absorb_q <= (state_q == S_SWEEP);
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    cnt_q <= cnt_d;
    t_q   <= t_d;
    r_q   <= r_d;
    ell_q <= ell_d;
  end

  always_comb begin
    ctrl.load   = accept;
    ctrl.build  = build_go;
    ctrl.sweep  = (state_q == S_SWEEP);
    ctrl.absorb = absorb_q;
    ctrl.tap    = (cnt_q == '0);
    ctrl.amount = build_go ? s_q : SHIFT_W'(1);
  end

  xsimw_datapath #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .z_o    (z)
  );

  xsimw_min_track #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_min_track (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .z_i    (z),
    .min_o  (min_w)
  );

  assign r8        = {2'b00, r_q};
  assign ell8      = {2'b00, ell_q};
  assign twice_r   = {1'b0, r_q, 1'b0};
  assign twice_ell = {1'b0, ell_q, 1'b0};

  assign result_valid_o      = (state_q == S_DONE);
  assign min_weight_o        = min_w;
  assign conjecture_broken_o = (min_w == WEIGHT_W'(2)) && (r8 != twice_ell) &&
                               (r8 != ell8) && (ell8 != twice_r) &&
                               ((twice_r + ell8) <= WordW8);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted word did not raise busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_strobe_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == S_DRAIN)
    else $error("result shown without draining the last word");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (min_weight_o != '0) &&
                       (min_weight_o <= WEIGHT_W'(WORD_WIDTH)))
    else $error("minimum weight out of range");

  a_build_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    build_go |-> s_q < WordW7)
    else $error("doubling pass with shift beyond word");

endmodule
`default_nettype wire

/* test/tb_xorshift_inverse_min_weight.sv */
// Testbench for xorshift_inverse_min_weight: feeds shift pairs through start/busy and
// checks every result word against a typed row value or a local search of the inverse-mix minimum weight.
// Depends on xsimw_pkg and the block's RTL only.
`timescale 1ns / 1ps
module tb_xorshift_inverse_min_weight;
  import xsimw_pkg::*;

  localparam int WORD_WIDTH  = 64;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_PAIRS = 750;
  localparam int CALM_PAIRS   = 100;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIRECTED_ROWS = 18;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                broken;
  } weight_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  r;
    logic [FIELD_W-1:0]  l;
    logic                typed;
    logic [WEIGHT_W-1:0] weight;
    logic                broken;
  } pair_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [FIELD_W-1:0]  right_shift_i;
  logic [FIELD_W-1:0]  left_shift_i;
  logic                result_valid_o;
  logic [WEIGHT_W-1:0] min_weight_o;
  logic                conjecture_broken_o;

  weight_word_t pending_weights[$];
  pair_row_t    directed_rows[DIRECTED_ROWS];
  int           mismatches;
  int           cycle_count;
  bit           calm_phase;

  xorshift_inverse_min_weight #(
    .WORD_WIDTH(WORD_WIDTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .right_shift_i      (right_shift_i),
    .left_shift_i       (left_shift_i),
    .result_valid_o     (result_valid_o),
    .min_weight_o       (min_weight_o),
    .conjecture_broken_o(conjecture_broken_o)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic logic [WORD_WIDTH-1:0] unwind_xor(logic [WORD_WIDTH-1:0] v, int s,
                                                       bit to_left);
    logic [WORD_WIDTH-1:0] acc;
    logic [WORD_WIDTH-1:0] t;
    acc = '0;
    t = v;
    for (int k = 0; k < WORD_WIDTH && t != 0; k++) begin
      acc ^= t;
      if (s == 0 || s >= WORD_WIDTH) break;
      t = to_left ? (t << s) : (t >> s);
    end
    return acc;
  endfunction

  function automatic weight_word_t predict_min_weight(logic [FIELD_W-1:0] r,
                                                      logic [FIELD_W-1:0] l);
    logic [WORD_WIDTH-1:0] y;
    logic [WORD_WIDTH-1:0] z;
    int best;
    int c;
    int rr;
    int ll;
    weight_word_t res;
    best = 2 * WORD_WIDTH;
    rr = r;
    ll = l;
    for (int i = 0; i < WORD_WIDTH; i++) begin
      y = unwind_xor(64'd1 << i, ll, 1'b1);
      z = unwind_xor(y, rr, 1'b0);
      c = $countones(z);
      if (c < best) best = c;
    end
    res.weight = best[WEIGHT_W-1:0];
    res.broken = (best == 2) && (rr != 2 * ll) && (rr != ll) && (ll != 2 * rr) &&
                 (2 * rr + ll <= WORD_WIDTH);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // one shift pair: optional idle burst, then hold start until taken
  task automatic send_pair(logic [FIELD_W-1:0] r, logic [FIELD_W-1:0] l, bit typed,
                           weight_word_t want);
    bit taken;
    if (!calm_phase && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    start_i <= 1'b1;
    right_shift_i <= r;
    left_shift_i <= l;
    do begin
      @(posedge clk_i);
      taken = start_i && !busy_o;
    end while (!taken);
    pending_weights.push_back(typed ? want : predict_min_weight(r, l));
    @(negedge clk_i);
  endtask

  task automatic drain_pending();
    start_i <= 1'b0;
    while (pending_weights.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    weight_word_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** xorshift_inverse_min_weight: FAILED **");
      $finish;
    end
    if (rst_ni && result_valid_o) begin
      if (pending_weights.size() == 0) begin
        report_mismatch("unexpected word, weight", min_weight_o, 0);
      end else begin
        want = pending_weights.pop_front();
        if (min_weight_o !== want.weight) report_mismatch("min_weight", min_weight_o, want.weight);
        if (conjecture_broken_o !== want.broken) begin
          report_mismatch("conjecture_broken", conjecture_broken_o, want.broken);
        end
      end
    end
  end

  initial begin
    weight_word_t want;
    logic [FIELD_W-1:0] r;
    logic [FIELD_W-1:0] l;
    mismatches = 0;
    cycle_count = 0;
    calm_phase = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    right_shift_i = '0;
    left_shift_i = '0;

    directed_rows = '{
      '{6'd0,  6'd0,  1'b1, 7'd1, 1'b0},
      '{6'd63, 6'd63, 1'b1, 7'd1, 1'b0},
      '{6'd0,  6'd63, 1'b0, 7'd0, 1'b0},
      '{6'd63, 6'd0,  1'b0, 7'd0, 1'b0},
      '{6'd0,  6'd5,  1'b0, 7'd0, 1'b0},
      '{6'd9,  6'd0,  1'b0, 7'd0, 1'b0},
      '{6'd1,  6'd1,  1'b0, 7'd0, 1'b0},
      '{6'd1,  6'd2,  1'b0, 7'd0, 1'b0},
      '{6'd2,  6'd1,  1'b0, 7'd0, 1'b0},
      '{6'd1,  6'd63, 1'b0, 7'd0, 1'b0},
      '{6'd63, 6'd1,  1'b0, 7'd0, 1'b0},
      '{6'd32, 6'd32, 1'b0, 7'd0, 1'b0},
      '{6'd21, 6'd22, 1'b0, 7'd0, 1'b0},
      '{6'd42, 6'd21, 1'b0, 7'd0, 1'b0},
      '{6'd13, 6'd7,  1'b0, 7'd0, 1'b0},
      '{6'd5,  6'd17, 1'b0, 7'd0, 1'b0},
      '{6'd31, 6'd2,  1'b0, 7'd0, 1'b0},
      '{6'd42, 6'd63, 1'b0, 7'd0, 1'b0}
    };

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      want.weight = directed_rows[i].weight;
      want.broken = directed_rows[i].broken;
      send_pair(directed_rows[i].r, directed_rows[i].l, directed_rows[i].typed, want);
    end
    drain_pending();

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      calm_phase = (n >= RANDOM_PAIRS - CALM_PAIRS);
      if (n == RANDOM_PAIRS / 2) drain_pending();
      case ($urandom_range(0, 4))
        0: begin
          l = $urandom_range(0, 63);
          r = l;
        end
        1: begin
          l = $urandom_range(0, 31);
          r = l << 1;
          if ($urandom_range(0, 1)) {r, l} = {l, r};
        end
        2: begin
          r = $urandom_range(1, 21);
          l = $urandom_range(1, 64 - 2 * r);
        end
        default: begin
          r = $urandom_range(0, 63);
          l = $urandom_range(0, 63);
        end
      endcase
      send_pair(r, l, 1'b0, want);
    end
    start_i <= 1'b0;

    while (pending_weights.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** xorshift_inverse_min_weight: PASSED **");
    end else begin
      $display("** xorshift_inverse_min_weight: FAILED **");
    end
    $finish;
  end

endmodule
